// ===== rtl/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg
// shared constants, types and command/status structs of the half-band
// decimator
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int HALF_TAPS    = 48;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 24;

  localparam int NTAPS  = 4 * HALF_TAPS - 1;   // filter length
  localparam int HLEN   = NTAPS - 1;           // stored history per channel
  localparam int CENTRE = 2 * HALF_TAPS - 1;   // centre tap position

  // fixed item field widths
  localparam int CH_W  = 3;
  localparam int CI_W  = 6;
  localparam int CFG_W = 4;

  localparam int MEM_DEPTH = MAX_CHANNELS * HLEN;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int OFF_W     = $clog2(HLEN);
  localparam int CT_AW     = $clog2(HALF_TAPS);
  localparam int K_W       = $clog2(HALF_TAPS + 1);
  localparam int ACC_W     = SAMPLE_BITS + COEF_BITS + 1 + $clog2(HALF_TAPS) + 2;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CALC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    action_t                 action;
    logic [CH_W-1:0]         channel;
    logic [SAMPLE_BITS-1:0]  sample_in;
    logic [CI_W-1:0]         coef_index;
    logic [COEF_BITS-1:0]    coef_value;
  } item_t;

  typedef struct packed {
    logic              capture;
    logic              coef_write;
    logic              commit;
    logic              acc_clear;
    logic              rd_en;
    logic              rd_centre;
    logic [K_W-1:0]    rd_k;
    logic              clr_en;
    logic [MEM_AW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_active;
    logic phase_odd;
    logic busy;
  } status_t;

endpackage

// ===== rtl/hbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbd_ctrl
// sequencer: memory clearing pass, item dispatch, tap pair loop, finish
// ----------------------------------------------------------------------------
module hbd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_busy,
  input  hbd_pkg::status_t status,
  output hbd_pkg::cmd_t    cmd,
  output logic             out_load
);
  import hbd_pkg::*;

  state_t            state, state_next;
  logic [MEM_AW-1:0] clr_cnt, clr_cnt_next;
  logic [K_W-1:0]    k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      k       <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      k       <= k_next;
    end
  end

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    k_next       = k;
    cmd          = '0;
    cmd.rd_k     = k;
    cmd.clr_addr = clr_cnt;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en   = 1'b1;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == MEM_AW'(MEM_DEPTH - 1)) begin
          clr_cnt_next = '0;
          state_next   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        k_next     = '0;
        state_next = ST_IDLE;
        if (status.is_load) begin
          cmd.coef_write = 1'b1;
        end else if (status.is_active) begin
          if (status.phase_odd) begin
            cmd.commit = 1'b1;
          end else begin
            cmd.acc_clear = 1'b1;
            state_next    = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_centre = (k == K_W'(HALF_TAPS));
        k_next        = k + 1'b1;
        if (k == K_W'(HALF_TAPS)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/hbd_datapath.sv =====
// ----------------------------------------------------------------------------
// hbd_datapath
// history and coefficient memories, pair adder, multiplier, accumulator,
// rounding and saturation
// ----------------------------------------------------------------------------
module hbd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hbd_pkg::CFG_W-1:0]     cfg_data,
  input  hbd_pkg::item_t                item,
  input  hbd_pkg::cmd_t                 cmd,
  output hbd_pkg::status_t              status,
  output logic [hbd_pkg::CH_W-1:0]      res_channel,
  output logic [hbd_pkg::SAMPLE_BITS-1:0] res_sample,
  output logic                          res_clip
);
  import hbd_pkg::*;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_BITS - 2);
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] hist_mem [MEM_DEPTH];
  logic [COEF_BITS-1:0]   coef_mem [HALF_TAPS];

  logic [CFG_W-1:0]   active_ch;
  logic [OFF_W-1:0]   wp [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] phase;

  // captured item
  action_t                  cap_action;
  logic [CH_W-1:0]          cap_ch;
  logic [SAMPLE_BITS-1:0]   cap_sample;
  logic [CI_W-1:0]          cap_idx;
  logic [COEF_BITS-1:0]     cap_coef;
  logic [MEM_AW-1:0]        base;

  logic [CFG_W-1:0]   limit;
  logic [OFF_W-1:0]   wp_cur;
  logic [OFF_W:0]     sum_a, sum_b, off_a, off_b;
  logic [MEM_AW-1:0]  raddr_a, raddr_b, waddr;
  logic               mem_we;
  logic [SAMPLE_BITS-1:0] wdata;
  logic [CT_AW-1:0]   coef_raddr;

  // pipeline
  logic [SAMPLE_BITS-1:0]          rd_a, rd_b;
  logic [COEF_BITS-1:0]            rd_c;
  logic                            rd_v, rd_first, rd_centre;
  logic signed [SAMPLE_BITS:0]     s_reg;
  logic signed [COEF_BITS-1:0]     c_reg;
  logic                            s_v, s_centre;
  logic signed [ACC_W-1:0]         p_reg;
  logic                            p_v;
  logic signed [ACC_W-1:0]         acc;

  logic signed [SAMPLE_BITS:0]     s_next;
  logic signed [SAMPLE_BITS+COEF_BITS:0] prod;
  logic signed [ACC_W-1:0]         sum_r, q;
  logic [ACC_W-SAMPLE_BITS:0]      q_hi;

  always_ff @(posedge clk) begin
    if (rst) active_ch <= CFG_W'(2);
    else if (cfg_we) active_ch <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_action <= item.action;
      cap_ch     <= item.channel;
      cap_sample <= item.sample_in;
      cap_idx    <= item.coef_index;
      cap_coef   <= item.coef_value;
      base       <= MEM_AW'(item.channel) * MEM_AW'(HLEN);
    end
  end

  assign limit  = (active_ch < CFG_W'(MAX_CHANNELS)) ? active_ch : CFG_W'(MAX_CHANNELS);
  assign wp_cur = wp[cap_ch];

  assign status.is_load   = (cap_action == ACT_LOAD);
  assign status.is_active = (CFG_W'(cap_ch) < limit);
  assign status.phase_odd = phase[cap_ch];
  assign status.busy      = rd_v | s_v | p_v;

  // write pointer marks the oldest history entry of each channel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) wp[i] <= '0;
      phase <= '0;
    end else if (cmd.commit) begin
      wp[cap_ch]    <= (wp_cur == OFF_W'(HLEN - 1)) ? '0 : wp_cur + 1'b1;
      phase[cap_ch] <= ~phase[cap_ch];
    end
  end

  // read offsets: port a takes x[2k] or the centre, port b takes x[HLEN-2k]
  always_comb begin
    sum_a = {1'b0, wp_cur} +
            (cmd.rd_centre ? (OFF_W+1)'(CENTRE) : ((OFF_W+1)'(cmd.rd_k) << 1));
    sum_b = {1'b0, wp_cur} + (OFF_W+1)'(HLEN) - ((OFF_W+1)'(cmd.rd_k) << 1);
    off_a = (sum_a >= (OFF_W+1)'(HLEN)) ? sum_a - (OFF_W+1)'(HLEN) : sum_a;
    off_b = (sum_b >= (OFF_W+1)'(HLEN)) ? sum_b - (OFF_W+1)'(HLEN) : sum_b;
  end

  assign raddr_a    = base + MEM_AW'(off_a[OFF_W-1:0]);
  assign raddr_b    = base + MEM_AW'(off_b[OFF_W-1:0]);
  assign mem_we     = cmd.clr_en | cmd.commit;
  assign waddr      = cmd.clr_en ? cmd.clr_addr : base + MEM_AW'(wp_cur);
  assign wdata      = cmd.clr_en ? '0 : cap_sample;
  assign coef_raddr = cmd.rd_centre ? '0 : cmd.rd_k[CT_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[waddr] <= wdata;
    rd_a <= hist_mem[raddr_a];
    rd_b <= hist_mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en && (cmd.clr_addr < MEM_AW'(HALF_TAPS))) begin
      coef_mem[cmd.clr_addr[CT_AW-1:0]] <= '0;
    end else if (cmd.coef_write && (cap_idx < CI_W'(HALF_TAPS))) begin
      coef_mem[cap_idx[CT_AW-1:0]] <= cap_coef;
    end
    rd_c <= coef_mem[coef_raddr];
  end

  // pipeline valid tags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      s_v  <= 1'b0;
      p_v  <= 1'b0;
    end else begin
      rd_v <= cmd.rd_en;
      s_v  <= rd_v;
      p_v  <= s_v;
    end
  end

  // first pair pairs the oldest sample with the incoming one
  always_comb begin
    if (rd_centre) begin
      s_next = {rd_a[SAMPLE_BITS-1], rd_a};
    end else begin
      s_next = signed'({rd_a[SAMPLE_BITS-1], rd_a}) +
               (rd_first ? signed'({cap_sample[SAMPLE_BITS-1], cap_sample})
                         : signed'({rd_b[SAMPLE_BITS-1], rd_b}));
    end
  end

  assign prod = s_reg * c_reg;

  always_ff @(posedge clk) begin
    rd_first  <= (cmd.rd_k == '0);
    rd_centre <= cmd.rd_centre;
    s_reg     <= s_next;
    c_reg     <= signed'(rd_c);
    s_centre  <= rd_centre;
    p_reg     <= s_centre ? (ACC_W'(s_reg) <<< (COEF_BITS - 2)) : ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) acc <= '0;
    else if (p_v)      acc <= acc + p_reg;
  end

  // round half up, drop fraction bits, saturate
  always_comb begin
    sum_r = acc + RND;
    q     = sum_r >>> (COEF_BITS - 1);
    q_hi  = q[ACC_W-1:SAMPLE_BITS-1];
    if ((&q_hi) || !(|q_hi)) begin
      res_sample = q[SAMPLE_BITS-1:0];
      res_clip   = 1'b0;
    end else begin
      res_sample = q[ACC_W-1] ? SAT_MIN : SAT_MAX;
      res_clip   = 1'b1;
    end
  end

  assign res_channel = cap_ch;

endmodule

// ===== rtl/halfband_decimator_by_two.sv =====
// ----------------------------------------------------------------------------
// halfband_decimator_by_two
// multichannel 191-tap half-band fir, decimating by two
// ----------------------------------------------------------------------------
// Items arrive on the s_axis stream: tuser selects a coefficient load or an
// audio sample. A load writes one of the 48 outer coefficients. A sample of
// an active channel enters that channel's 190-entry history; on the first,
// third, fifth and later samples of the channel one filtered output item
// leaves on m_axis. After reset the block sweeps the history memory (all 1520
// entries, one entry a cycle) and holds s_axis_tready low during the sweep;
// configuration writes are taken throughout. An output-producing sample
// keeps s_axis_tready low after its acceptance while it passes through one
// dispatch state, 49 memory reads (48 tap pairs through the two read ports
// of the history memory plus the centre tap, feeding one
// multiply-accumulate), the pipeline drain state and the finish state.
// Loads, odd-phase samples and samples of inactive channels pass only
// through the dispatch state before the block returns to idle. A finished
// item sits in the output register while the next items are accepted; only a
// second result stalls in the finish state until the first has been taken.
// ----------------------------------------------------------------------------
module halfband_decimator_by_two (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: number of active channels
  input  logic                           cfg_we,
  input  logic [hbd_pkg::CFG_W-1:0]      cfg_data,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // channel[2:0], sample_in[26:3], coef_index[32:27], coef_value[56:33], zero
  input  logic [63:0]                    s_axis_tdata,
  // action[0]: 0 load coefficient, 1 sample
  input  logic [0:0]                     s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_channel[2:0], sample_out[26:3], zero
  output logic [31:0]                    m_axis_tdata,
  // clipped[0]
  output logic [0:0]                     m_axis_tuser
);
  import hbd_pkg::*;

  item_t   item;
  cmd_t    cmd;
  status_t status;
  logic    out_load;
  logic    out_busy;

  logic [CH_W-1:0]        res_channel;
  logic [SAMPLE_BITS-1:0] res_sample;
  logic                   res_clip;

  // output register
  logic                   out_valid;
  logic [CH_W-1:0]        out_channel;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   clipped;

  // unpack the input item
  assign item.action     = action_t'(s_axis_tuser[0]);
  assign item.channel    = s_axis_tdata[2:0];
  assign item.sample_in  = s_axis_tdata[26:3];
  assign item.coef_index = s_axis_tdata[32:27];
  assign item.coef_value = s_axis_tdata[56:33];

  // a new result must wait while the previous one is still held
  assign out_busy = out_valid & ~m_axis_tready;

  hbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_busy (out_busy),
    .status   (status),
    .cmd      (cmd),
    .out_load (out_load)
  );

  hbd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .res_channel (res_channel),
    .res_sample  (res_sample),
    .res_clip    (res_clip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= res_channel;
      sample_out  <= res_sample;
      clipped     <= res_clip;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, sample_out, out_channel};
  assign m_axis_tuser  = clipped;

endmodule
